// ----- sv/lscan_pkg.sv -----
package lscan_pkg;

   // CORDIC chain geometry
   localparam int CORDIC_STEPS = 16;
   localparam int MAX_BEAMS    = 4096;
   localparam int CNT_W        = 12;
   localparam logic [CNT_W-1:0] CNT_LIMIT =
      CNT_W'(((MAX_BEAMS - 1) > 4095) ? 4095 : (MAX_BEAMS - 1));

   localparam int RANGE_W = 16;
   localparam int ANGLE_W = 16;
   localparam int POS_W   = 17;
   localparam int XY_W    = 36;   // Q8.24 plus CORDIC growth and sign
   localparam int Z_W     = 34;   // residual angle, 2^32 units per turn
   localparam int STEP_W  = 5;    // covers all 24 table entries
   localparam int CSR_IDX_W = 8;

   localparam logic [15:0] GAIN_Q16 = 16'd39797;

   localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(65535);
   localparam logic signed [POS_W-1:0] POS_MIN = -POS_W'(65535);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_RANGE_LOW   = 8'd0,
      REG_RANGE_HIGH  = 8'd1,
      REG_ANGLE_START = 8'd2,
      REG_ANGLE_STEP  = 8'd3
   } csr_reg_type;

   // one point in flight through the rotation chain
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
      logic                   fold;
      logic [CNT_W-1:0]       beam;
      logic [CNT_W-1:0]       kept;
   } point_type;

   // arctan(2^-i) in units of 2^32 per turn
   function automatic logic signed [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:    v = Z_W'(536870912);
         5'd1:    v = Z_W'(316933406);
         5'd2:    v = Z_W'(167458907);
         5'd3:    v = Z_W'(85004756);
         5'd4:    v = Z_W'(42667331);
         5'd5:    v = Z_W'(21354465);
         5'd6:    v = Z_W'(10679838);
         5'd7:    v = Z_W'(5340245);
         5'd8:    v = Z_W'(2670163);
         5'd9:    v = Z_W'(1335087);
         5'd10:   v = Z_W'(667544);
         5'd11:   v = Z_W'(333772);
         5'd12:   v = Z_W'(166886);
         5'd13:   v = Z_W'(83443);
         5'd14:   v = Z_W'(41722);
         5'd15:   v = Z_W'(20861);
         5'd16:   v = Z_W'(10430);
         5'd17:   v = Z_W'(5215);
         5'd18:   v = Z_W'(2608);
         5'd19:   v = Z_W'(1304);
         5'd20:   v = Z_W'(652);
         5'd21:   v = Z_W'(326);
         5'd22:   v = Z_W'(163);
         5'd23:   v = Z_W'(81);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- sv/laser_scan_polar_to_cartesian.sv -----
// Laser scan polar-to-Cartesian converter.
// req_ channel: one range sample per transaction (Q8.8 metres) with a
//   no-return flag and a scan-start flag. Every accepted sample advances the
//   beam angle and beam counter; only nonzero returns inside the inclusive
//   [range_low, range_high] window produce a point.
// rsp_ channel: one transaction per kept sample, x/y in signed Q8.8 metres
//   plus beam and kept-point indices (both saturate at 4095).
// csr_ channel: always ready; index 0..3 = range_low, range_high,
//   angle_start, angle_step. Other indices are dropped.
// Path: a kept sample is registered in the front register at acceptance,
//   then in each CORDIC cell in turn, and reaches rsp_ through the output
//   register.
// Throughput: one sample per cycle while rsp_ready holds; the cell chain is the
//   pipeline, each cell doing one CORDIC iteration with a fixed shift.
// Stall: each cell holds its point while the next one cannot take it, so
//   bubbles collapse and req_ready only drops once every stage is occupied.
// Reset: clears the pipeline, restores register defaults, zeroes the running
//   angle and both counters.
module laser_scan_polar_to_cartesian (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lscan_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [15:0]                         csr_wdata,
   // samples in
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [lscan_pkg::RANGE_W-1:0]       req_range_sample,
   input  logic                                req_no_return,
   input  logic                                req_scan_start,
   // points out
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [lscan_pkg::POS_W-1:0]  rsp_x_pos,
   output logic signed [lscan_pkg::POS_W-1:0]  rsp_y_pos,
   output logic [lscan_pkg::CNT_W-1:0]         rsp_beam_number,
   output logic [lscan_pkg::CNT_W-1:0]         rsp_point_number
);
   import lscan_pkg::*;

   localparam int QW = XY_W - 16;   // width after dropping 16 fraction bits

   // configuration registers
   logic [RANGE_W-1:0] range_low_ff, range_high_ff;
   logic [ANGLE_W-1:0] angle_start_ff, angle_step_ff;

   // scan state
   logic [ANGLE_W-1:0] angle_ff;
   logic [CNT_W-1:0]   beam_ff, kept_ff;

   // front stage
   logic      front_valid_ff;
   point_type front_item_ff;
   logic      front_ready;

   // chain wiring
   logic      chain_valid [0:CORDIC_STEPS];
   logic      chain_ready [0:CORDIC_STEPS];
   point_type chain_item  [0:CORDIC_STEPS];

   // output register
   logic                    out_valid_ff;
   logic signed [POS_W-1:0] x_ff, y_ff;
   logic [CNT_W-1:0]        beam_out_ff, kept_out_ff;

   // accept-time decode
   logic               accept;
   logic [ANGLE_W-1:0] cur_angle;
   logic [CNT_W-1:0]   cur_beam, cur_kept;
   logic               keep;
   logic               fold;
   logic [ANGLE_W-1:0] folded_angle;
   logic [31:0]        scaled_range;
   point_type          front_in;

   logic signed [POS_W-1:0] x_in, y_in;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff   <= '0;
         range_high_ff  <= '1;
         angle_start_ff <= '0;
         angle_step_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_RANGE_LOW:   range_low_ff   <= csr_wdata;
            REG_RANGE_HIGH:  range_high_ff  <= csr_wdata;
            REG_ANGLE_START: angle_start_ff <= csr_wdata;
            REG_ANGLE_STEP:  angle_step_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- sample decode ----------------
   assign req_ready = front_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cur_angle = req_scan_start ? angle_start_ff : angle_ff;
      cur_beam  = req_scan_start ? '0 : beam_ff;
      cur_kept  = req_scan_start ? '0 : kept_ff;
      keep = (req_range_sample != '0) && !req_no_return &&
             (req_range_sample >= range_low_ff) && (req_range_sample <= range_high_ff);
      // angles in the back half-plane are rotated by a half turn and the
      // result negated, keeping the CORDIC inside its convergence range
      fold = cur_angle[ANGLE_W-1] ^ cur_angle[ANGLE_W-2];
      folded_angle = fold ? {~cur_angle[ANGLE_W-1], cur_angle[ANGLE_W-2:0]} : cur_angle;
      // pre-scale by 1/K so the rotation comes out gain-free, Q8.24
      scaled_range = 32'(req_range_sample) * 32'(GAIN_Q16);
      front_in.x    = XY_W'(scaled_range);
      front_in.y    = '0;
      front_in.z    = Z_W'({{(Z_W-ANGLE_W-16){folded_angle[ANGLE_W-1]}}, folded_angle, 16'd0});
      front_in.fold = fold;
      front_in.beam = cur_beam;
      front_in.kept = cur_kept;
   end

   // angle and beam counter advance on every accepted sample, kept counter on kept ones
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         beam_ff  <= '0;
         kept_ff  <= '0;
      end else if (accept) begin
         angle_ff <= cur_angle + angle_step_ff;
         beam_ff  <= (cur_beam < CNT_LIMIT) ? cur_beam + 1'b1 : CNT_LIMIT;
         if (keep) begin
            kept_ff <= (cur_kept < CNT_LIMIT) ? cur_kept + 1'b1 : CNT_LIMIT;
         end else begin
            kept_ff <= cur_kept;
         end
      end
   end

   // ---------------- front register ----------------
   assign front_ready = !front_valid_ff || chain_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_ready) begin
         front_valid_ff <= accept && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (front_ready && accept && keep) begin
         front_item_ff <= front_in;
      end
   end

   // ---------------- rotation chain ----------------
   assign chain_valid[0] = front_valid_ff;
   assign chain_item[0]  = front_item_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      lscan_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (STEP_W'(i)),
         .in_valid  (chain_valid[i]),
         .in_item   (chain_item[i]),
         .in_ready  (chain_ready[i]),
         .out_valid (chain_valid[i+1]),
         .out_item  (chain_item[i+1]),
         .out_ready (chain_ready[i+1])
      );
   end

   // ---------------- round, unfold, saturate ----------------
   function automatic logic signed [POS_W-1:0] to_q88(input logic signed [XY_W-1:0] v,
                                                       input logic neg);
      logic signed [XY_W-1:0] rnd;
      logic signed [QW:0]     q;
      rnd = v + XY_W'(32768);
      q = (QW+1)'(rnd >>> 16);
      if (neg) begin
         q = -q;
      end
      if (q > (QW+1)'(65535)) begin
         return POS_MAX;
      end else if (q < -(QW+1)'(65535)) begin
         return POS_MIN;
      end
      return POS_W'(q);
   endfunction

   assign x_in = to_q88(chain_item[CORDIC_STEPS].x, chain_item[CORDIC_STEPS].fold);
   assign y_in = to_q88(chain_item[CORDIC_STEPS].y, chain_item[CORDIC_STEPS].fold);

   assign chain_ready[CORDIC_STEPS] = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (chain_ready[CORDIC_STEPS]) begin
         out_valid_ff <= chain_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (chain_ready[CORDIC_STEPS] && chain_valid[CORDIC_STEPS]) begin
         x_ff        <= x_in;
         y_ff        <= y_in;
         beam_out_ff <= chain_item[CORDIC_STEPS].beam;
         kept_out_ff <= chain_item[CORDIC_STEPS].kept;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_x_pos        = x_ff;
   assign rsp_y_pos        = y_ff;
   assign rsp_beam_number  = beam_out_ff;
   assign rsp_point_number = kept_out_ff;

endmodule

// ----- sv/lscan_cell.sv -----
module lscan_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [lscan_pkg::STEP_W-1:0] step_idx,
   input  logic                         in_valid,
   input  lscan_pkg::point_type         in_item,
   output logic                         in_ready,
   output logic                         out_valid,
   output lscan_pkg::point_type         out_item,
   input  logic                         out_ready
);
   import lscan_pkg::*;

   logic      valid_ff;
   point_type item_ff;
   point_type item_in;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;
   logic signed [Z_W-1:0]  da;

   // step index is tied off per cell, so shifts and table fold to constants
   always_comb begin
      dx = in_item.y >>> step_idx;
      dy = in_item.x >>> step_idx;
      da = atan_entry(step_idx);
      item_in = in_item;
      if (!in_item.z[Z_W-1]) begin
         item_in.x = in_item.x - dx;
         item_in.y = in_item.y + dy;
         item_in.z = in_item.z - da;
      end else begin
         item_in.x = in_item.x + dx;
         item_in.y = in_item.y - dy;
         item_in.z = in_item.z + da;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule
